// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GAPS_AST_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GAPS_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/gaps_pkg.sv -----
// Shared constants, types and direction tables of the grid path search unit.
`default_nettype none
package gaps_pkg;

	localparam int MAX_WIDTH_DEF  = 8;
	localparam int MAX_HEIGHT_DEF = 8;
	localparam int COST_BITS_DEF  = 24;
	localparam int MAX_RESULTS    = 64;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIAG_COST   = 2'd2;

	localparam logic [3:0] GRID_SIZE_RST = 4'd8;
	localparam logic [9:0] DIAG_COST_RST = 10'd362;
	localparam logic [9:0] STRAIGHT_COST = 10'd256;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_RUN  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NOTF,
		ST_SCAN,
		ST_SCAN_END,
		ST_PICK,
		ST_NB_RD,
		ST_NB_MUL,
		ST_NB_G,
		ST_NB_WR,
		ST_TR_WR,
		ST_TR_RD,
		ST_TR_PAR,
		ST_EM_RD,
		ST_EM_LD
	} state_t;

	function automatic logic signed [1:0] dir_dx(input logic [2:0] d);
		logic signed [1:0] r;
		unique case (d)
			3'd0, 3'd1: r = 2'sd0;
			3'd2, 3'd4, 3'd6: r = -2'sd1;
			default: r = 2'sd1;
		endcase
		return r;
	endfunction

	function automatic logic signed [1:0] dir_dy(input logic [2:0] d);
		logic signed [1:0] r;
		unique case (d)
			3'd2, 3'd3: r = 2'sd0;
			3'd0, 3'd4, 3'd5: r = 2'sd1;
			default: r = -2'sd1;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- design/gaps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gaps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- design/grid_astar_path_search_unit.sv -----
// Top level of the grid A* path search unit.
//
//  channel   | handshake              | contents
//  ----------+------------------------+-------------------------------------------
//  cfg       | cfg_wr_en              | cfg_index, cfg_wr_data (no read-back)
//  s_axis    | s_axis_tvalid/tready   | tuser mode, tdata cell and search fields
//  m_axis    | m_axis_tvalid/tready   | tdata path cell, tuser found, tlast
//
// A run sweeps the node memory for the best open entry before it expands each cell
// and visits its neighbours; at the goal it traces the path back and emits it as
// result words. Reset clears control state; memories hold their contents.
// One search runs at a time; a stalled result holds the search in place.
`default_nettype none
module grid_astar_path_search_unit #(
	parameter int MAX_WIDTH  = gaps_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = gaps_pkg::MAX_HEIGHT_DEF,
	parameter int COST_BITS  = gaps_pkg::COST_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [gaps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gaps_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// cell_x[2:0] cell_y[5:3] cell_cost[13:6] cell_blocked[14]
	// start_x[17:15] start_y[20:18] goal_x[23:21] goal_y[26:24]
	input  wire logic [31:0]                     s_axis_tdata,
	// mode[0]
	input  wire logic                            s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// path_x[2:0] path_y[5:3]
	output logic [7:0]                           m_axis_tdata,
	// found[0]
	output logic                                 m_axis_tuser,
	output logic                                 m_axis_tlast
);

	localparam int NCELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW     = $clog2(NCELLS);
	localparam int LW     = AW + 1;
	localparam int XW     = $clog2(MAX_WIDTH);
	localparam int YW     = $clog2(MAX_HEIGHT);
	localparam int CM     = XW > YW ? XW : YW;
	localparam int CW     = CM > 3 ? CM : 3;
	localparam int SW     = CW + 2;
	localparam int PW     = XW + YW;

	typedef struct packed {
		logic                 closed;
		logic [AW-1:0]        seq;
		logic [2:0]           par;
		logic [COST_BITS-1:0] g;
		logic [COST_BITS-1:0] f;
	} node_t;

	function automatic logic [AW-1:0] cell_idx(input logic [XW-1:0] x, input logic [YW-1:0] y);
		return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
	endfunction

	function automatic logic [COST_BITS-1:0] heur(input logic [CW-1:0] x, input logic [CW-1:0] y,
			input logic [2:0] gx, input logic [2:0] gy);
		logic [CW-1:0] gxe;
		logic [CW-1:0] gye;
		logic [CW-1:0] dx;
		logic [CW-1:0] dy;
		logic [CW:0]   sum;
		gxe = CW'(gx);
		gye = CW'(gy);
		dx  = x > gxe ? x - gxe : gxe - x;
		dy  = y > gye ? y - gye : gye - y;
		sum = {1'b0, dx} + {1'b0, dy};
		return COST_BITS'({sum, 8'h00});
	endfunction

	function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
			input logic [COST_BITS-1:0] b);
		logic [COST_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_BITS] ? {COST_BITS{1'b1}} : s[COST_BITS-1:0];
	endfunction

	gaps_pkg::state_t state_q, state_nx;

	logic [3:0]           grid_w_q, grid_h_q;
	logic [9:0]           diag_q;
	logic [2:0]           start_x_q, start_y_q, goal_x_q, goal_y_q;
	logic signed [SW-1:0] w_eff_q, h_eff_q, w_eff, h_eff;
	logic [NCELLS-1:0]    seen_q;
	logic [AW-1:0]        seq_cnt_q;
	logic [XW-1:0]        scan_x_q;
	logic [YW-1:0]        scan_y_q;
	logic                 scan_v_s1;
	logic [AW-1:0]        scan_idx_s1;
	logic [XW-1:0]        scan_x_s1;
	logic [YW-1:0]        scan_y_s1;
	logic                 have_q;
	node_t                best_q;
	logic [XW-1:0]        best_x_q, cur_x_q, nb_x_q, at_x_q;
	logic [YW-1:0]        best_y_q, cur_y_q, nb_y_q, at_y_q;
	logic [COST_BITS-1:0] cur_g_q, ng_q;
	logic [2:0]           d_q;
	logic [AW-1:0]        nb_idx_q;
	logic [11:0]          step_q;
	logic [LW-1:0]        len_q;
	logic [5:0]           n_q;
	logic                 out_vld_q, out_found_q, out_last_q;
	logic [2:0]           out_x_q, out_y_q;

	logic                 node_we, node_re, cell_we, cell_re, pb_we, pb_re;
	logic [AW-1:0]        node_waddr, node_raddr, cell_waddr, cell_raddr, pb_waddr, pb_raddr;
	node_t                node_wdata, node_rdata;
	logic [8:0]           cell_wdata, cell_rdata;
	logic [PW-1:0]        pb_wdata, pb_rdata;

	logic                 in_acc, in_mode, in_blk, start_ok, load_ok;
	logic [2:0]           in_cx, in_cy, in_sx, in_sy, in_gx, in_gy;
	logic [7:0]           in_cost;
	logic                 scan_last, cand_better, best_is_goal, d_last;
	logic signed [SW-1:0] nxs, nys, pxs, pys;
	logic                 nb_in, nb_closed, nb_open, upd, at_is_start, tr_full;
	logic                 out_free, out_load, em_last;
	logic [AW-1:0]        nb_idx, start_idx;
	logic [19:0]          prod;
	logic [COST_BITS-1:0] ng_sum, nf_sum, start_h;
	logic [9:0]           step_dist;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign in_mode = s_axis_tuser;
	assign in_cx   = s_axis_tdata[2:0];
	assign in_cy   = s_axis_tdata[5:3];
	assign in_cost = s_axis_tdata[13:6];
	assign in_blk  = s_axis_tdata[14];
	assign in_sx   = s_axis_tdata[17:15];
	assign in_sy   = s_axis_tdata[20:18];
	assign in_gx   = s_axis_tdata[23:21];
	assign in_gy   = s_axis_tdata[26:24];

	assign w_eff = (grid_w_q == 4'd0) ? SW'(1) :
		(SW'(grid_w_q) > SW'(MAX_WIDTH) ? SW'(MAX_WIDTH) : SW'(grid_w_q));
	assign h_eff = (grid_h_q == 4'd0) ? SW'(1) :
		(SW'(grid_h_q) > SW'(MAX_HEIGHT) ? SW'(MAX_HEIGHT) : SW'(grid_h_q));

	assign start_ok  = (SW'(in_sx) < w_eff) && (SW'(in_sy) < h_eff);
	assign load_ok   = (32'(in_cx) < MAX_WIDTH) && (32'(in_cy) < MAX_HEIGHT);
	assign start_idx = cell_idx(XW'(in_sx), YW'(in_sy));
	assign start_h   = heur(CW'(XW'(in_sx)), CW'(YW'(in_sy)), in_gx, in_gy);

	assign scan_last = (scan_x_q == XW'(MAX_WIDTH - 1)) && (scan_y_q == YW'(MAX_HEIGHT - 1));
	assign cand_better = scan_v_s1 && seen_q[scan_idx_s1] && !node_rdata.closed &&
		(!have_q || (node_rdata.f < best_q.f) ||
		((node_rdata.f == best_q.f) && (node_rdata.seq < best_q.seq)));
	assign best_is_goal = (CW'(best_x_q) == CW'(goal_x_q)) && (CW'(best_y_q) == CW'(goal_y_q));
	assign d_last = (d_q == 3'd7);

	assign nxs = $signed(SW'(cur_x_q)) + SW'(gaps_pkg::dir_dx(d_q));
	assign nys = $signed(SW'(cur_y_q)) + SW'(gaps_pkg::dir_dy(d_q));
	assign nb_in = !nxs[SW-1] && !nys[SW-1] && (nxs < w_eff_q) && (nys < h_eff_q);
	assign nb_idx = cell_idx(XW'(nxs), YW'(nys));

	assign nb_closed = seen_q[nb_idx_q] && node_rdata.closed;
	assign nb_open   = seen_q[nb_idx_q] && !node_rdata.closed;
	assign step_dist = d_q[2] ? diag_q : gaps_pkg::STRAIGHT_COST;
	assign prod      = 20'(step_dist) * (20'd256 + {11'd0, cell_rdata[7:0], 1'b0});
	assign ng_sum    = sat_add(cur_g_q, COST_BITS'(step_q));
	assign nf_sum    = sat_add(ng_q, heur(CW'(nb_x_q), CW'(nb_y_q), goal_x_q, goal_y_q));
	assign upd       = !nb_open || (ng_q < node_rdata.g);

	assign at_is_start = (CW'(at_x_q) == CW'(start_x_q)) && (CW'(at_y_q) == CW'(start_y_q));
	assign tr_full     = (len_q == LW'(NCELLS - 1));
	assign pxs = $signed(SW'(at_x_q)) - SW'(gaps_pkg::dir_dx(node_rdata.par));
	assign pys = $signed(SW'(at_y_q)) - SW'(gaps_pkg::dir_dy(node_rdata.par));

	assign out_free = !out_vld_q || m_axis_tready;
	assign out_load = out_free &&
		(state_q == gaps_pkg::ST_NOTF || state_q == gaps_pkg::ST_EM_LD);
	assign em_last  = (len_q == LW'(0)) || (n_q == 6'(gaps_pkg::MAX_RESULTS - 1));

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			gaps_pkg::ST_IDLE: begin
				if (in_acc && in_mode == gaps_pkg::MODE_RUN) begin
					state_nx = start_ok ? gaps_pkg::ST_SCAN : gaps_pkg::ST_NOTF;
				end
			end
			gaps_pkg::ST_NOTF: begin
				if (out_free) state_nx = gaps_pkg::ST_IDLE;
			end
			gaps_pkg::ST_SCAN: begin
				if (scan_last) state_nx = gaps_pkg::ST_SCAN_END;
			end
			gaps_pkg::ST_SCAN_END: state_nx = gaps_pkg::ST_PICK;
			gaps_pkg::ST_PICK: begin
				if (!have_q) state_nx = gaps_pkg::ST_NOTF;
				else if (best_is_goal) state_nx = gaps_pkg::ST_TR_WR;
				else state_nx = gaps_pkg::ST_NB_RD;
			end
			gaps_pkg::ST_NB_RD: begin
				if (nb_in) state_nx = gaps_pkg::ST_NB_MUL;
				else if (d_last) state_nx = gaps_pkg::ST_SCAN;
			end
			gaps_pkg::ST_NB_MUL: begin
				if (cell_rdata[8] || nb_closed) begin
					state_nx = d_last ? gaps_pkg::ST_SCAN : gaps_pkg::ST_NB_RD;
				end else begin
					state_nx = gaps_pkg::ST_NB_G;
				end
			end
			gaps_pkg::ST_NB_G: state_nx = gaps_pkg::ST_NB_WR;
			gaps_pkg::ST_NB_WR: state_nx = d_last ? gaps_pkg::ST_SCAN : gaps_pkg::ST_NB_RD;
			gaps_pkg::ST_TR_WR: begin
				state_nx = (at_is_start || tr_full) ? gaps_pkg::ST_EM_RD : gaps_pkg::ST_TR_RD;
			end
			gaps_pkg::ST_TR_RD: state_nx = gaps_pkg::ST_TR_PAR;
			gaps_pkg::ST_TR_PAR: state_nx = gaps_pkg::ST_TR_WR;
			gaps_pkg::ST_EM_RD: state_nx = gaps_pkg::ST_EM_LD;
			gaps_pkg::ST_EM_LD: begin
				if (out_free) state_nx = em_last ? gaps_pkg::ST_IDLE : gaps_pkg::ST_EM_RD;
			end
			default: state_nx = gaps_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == gaps_pkg::ST_IDLE);
		cell_we    = 1'b0;
		cell_waddr = cell_idx(XW'(in_cx), YW'(in_cy));
		cell_wdata = {in_blk, in_cost};
		cell_re    = 1'b0;
		cell_raddr = nb_idx;
		node_we    = 1'b0;
		node_waddr = nb_idx_q;
		node_wdata = '0;
		node_re    = 1'b0;
		node_raddr = nb_idx;
		pb_we      = 1'b0;
		pb_waddr   = len_q[AW-1:0];
		pb_wdata   = {at_y_q, at_x_q};
		pb_re      = 1'b0;
		pb_raddr   = AW'(len_q - LW'(1));
		unique case (state_q)
			gaps_pkg::ST_IDLE: begin
				if (in_acc && in_mode == gaps_pkg::MODE_LOAD && load_ok) cell_we = 1'b1;
				if (in_acc && in_mode == gaps_pkg::MODE_RUN && start_ok) begin
					node_we    = 1'b1;
					node_waddr = start_idx;
					node_wdata = '{closed: 1'b0, seq: '0, par: 3'd0, g: '0, f: start_h};
				end
			end
			gaps_pkg::ST_SCAN: begin
				node_re    = 1'b1;
				node_raddr = cell_idx(scan_x_q, scan_y_q);
			end
			gaps_pkg::ST_PICK: begin
				if (have_q && !best_is_goal) begin
					node_we    = 1'b1;
					node_waddr = cell_idx(best_x_q, best_y_q);
					node_wdata = best_q;
					node_wdata.closed = 1'b1;
				end
			end
			gaps_pkg::ST_NB_RD: begin
				if (nb_in) begin
					node_re = 1'b1;
					cell_re = 1'b1;
				end
			end
			gaps_pkg::ST_NB_WR: begin
				if (upd) begin
					node_we    = 1'b1;
					node_wdata = '{closed: 1'b0, seq: nb_open ? node_rdata.seq : seq_cnt_q,
						par: d_q, g: ng_q, f: nf_sum};
				end
			end
			gaps_pkg::ST_TR_WR: pb_we = 1'b1;
			gaps_pkg::ST_TR_RD: begin
				node_re    = 1'b1;
				node_raddr = cell_idx(at_x_q, at_y_q);
			end
			gaps_pkg::ST_EM_RD: pb_re = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= gaps_pkg::ST_IDLE;
			grid_w_q  <= gaps_pkg::GRID_SIZE_RST;
			grid_h_q  <= gaps_pkg::GRID_SIZE_RST;
			diag_q    <= gaps_pkg::DIAG_COST_RST;
			seen_q    <= '0;
			scan_x_q  <= '0;
			scan_y_q  <= '0;
			scan_v_s1 <= 1'b0;
			have_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					gaps_pkg::REG_GRID_WIDTH:  grid_w_q <= cfg_wr_data[3:0];
					gaps_pkg::REG_GRID_HEIGHT: grid_h_q <= cfg_wr_data[3:0];
					gaps_pkg::REG_DIAG_COST:   diag_q   <= cfg_wr_data;
					default: begin
					end
				endcase
			end
			if (out_load) out_vld_q <= 1'b1;
			else if (m_axis_tready) out_vld_q <= 1'b0;
			scan_v_s1 <= (state_q == gaps_pkg::ST_SCAN);
			if (state_q == gaps_pkg::ST_IDLE || state_q == gaps_pkg::ST_PICK) have_q <= 1'b0;
			else if (cand_better) have_q <= 1'b1;
			unique case (state_q)
				gaps_pkg::ST_IDLE: begin
					if (in_acc && in_mode == gaps_pkg::MODE_RUN) begin
						seen_q <= {NCELLS{start_ok}} & (NCELLS'(1) << start_idx);
					end
				end
				gaps_pkg::ST_SCAN: begin
					if (scan_x_q == XW'(MAX_WIDTH - 1)) begin
						scan_x_q <= '0;
						scan_y_q <= scan_last ? '0 : scan_y_q + YW'(1);
					end else begin
						scan_x_q <= scan_x_q + XW'(1);
					end
				end
				gaps_pkg::ST_NB_WR: begin
					if (upd) seen_q[nb_idx_q] <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= cell_idx(scan_x_q, scan_y_q);
		scan_x_s1   <= scan_x_q;
		scan_y_s1   <= scan_y_q;
		if (cand_better) begin
			best_q   <= node_rdata;
			best_x_q <= scan_x_s1;
			best_y_q <= scan_y_s1;
		end
		unique case (state_q)
			gaps_pkg::ST_IDLE: begin
				start_x_q <= in_sx;
				start_y_q <= in_sy;
				goal_x_q  <= in_gx;
				goal_y_q  <= in_gy;
				w_eff_q   <= w_eff;
				h_eff_q   <= h_eff;
				seq_cnt_q <= AW'(1);
			end
			gaps_pkg::ST_NOTF: begin
				if (out_free) begin
					out_x_q     <= 3'd0;
					out_y_q     <= 3'd0;
					out_found_q <= 1'b0;
					out_last_q  <= 1'b1;
				end
			end
			gaps_pkg::ST_PICK: begin
				cur_x_q <= best_x_q;
				cur_y_q <= best_y_q;
				cur_g_q <= best_q.g;
				at_x_q  <= best_x_q;
				at_y_q  <= best_y_q;
				d_q     <= 3'd0;
				len_q   <= '0;
				n_q     <= '0;
			end
			gaps_pkg::ST_NB_RD: begin
				nb_x_q   <= XW'(nxs);
				nb_y_q   <= YW'(nys);
				nb_idx_q <= nb_idx;
				if (!nb_in) d_q <= d_q + 3'd1;
			end
			gaps_pkg::ST_NB_MUL: begin
				step_q <= prod[19:8];
				if (cell_rdata[8] || nb_closed) d_q <= d_q + 3'd1;
			end
			gaps_pkg::ST_NB_G: ng_q <= ng_sum;
			gaps_pkg::ST_NB_WR: begin
				d_q <= d_q + 3'd1;
				if (upd && !nb_open) seq_cnt_q <= seq_cnt_q + AW'(1);
			end
			gaps_pkg::ST_TR_WR: len_q <= len_q + LW'(1);
			gaps_pkg::ST_TR_PAR: begin
				at_x_q <= XW'(pxs);
				at_y_q <= YW'(pys);
			end
			gaps_pkg::ST_EM_RD: len_q <= len_q - LW'(1);
			gaps_pkg::ST_EM_LD: begin
				if (out_free) begin
					out_x_q     <= 3'(pb_rdata[XW-1:0]);
					out_y_q     <= 3'(pb_rdata[PW-1:XW]);
					out_found_q <= 1'b1;
					out_last_q  <= em_last;
					n_q         <= n_q + 6'd1;
				end
			end
			default: begin
			end
		endcase
	end

	gaps_ram #(.WIDTH(9), .DEPTH(NCELLS)) u_cell_ram (
		.clk(clk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
		.re(cell_re), .raddr(cell_raddr), .rdata(cell_rdata)
	);

	gaps_ram #(.WIDTH($bits(node_t)), .DEPTH(NCELLS)) u_node_ram (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
		.re(node_re), .raddr(node_raddr), .rdata(node_rdata)
	);

	gaps_ram #(.WIDTH(PW), .DEPTH(NCELLS)) u_path_ram (
		.clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(pb_wdata),
		.re(pb_re), .raddr(pb_raddr), .rdata(pb_rdata)
	);

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {2'b00, out_y_q, out_x_q};
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

// ----- design/gaps_chk.sv -----
// Port-level checker of the grid path search unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module gaps_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic       s_axis_tuser,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic       m_axis_tuser,
	input wire logic       m_axis_tlast
);

	`GAPS_AST_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled word changed")
	`GAPS_AST_SAME(a_notfound, m_axis_tvalid && !m_axis_tuser, m_axis_tlast && (m_axis_tdata == 8'd0), "bad not-found word")
	`GAPS_AST_NEXT(a_load_quiet, s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid, !m_axis_tvalid, "load gave a word")
	`GAPS_AST_NEXT(a_run_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready, "ready during search")

endmodule

bind grid_astar_path_search_unit gaps_chk u_gaps_chk (.*);
`default_nettype wire

// ----- sim/tb_grid_astar_path_search_unit.sv -----
// Testbench of the grid A* path search unit: directed and random grids against a search model.
module tb_grid_astar_path_search_unit;

	localparam int NCELLS     = 64;
	localparam int CYCLE_CAP  = 20000000;
	localparam longint unsigned COST_SAT = (64'd1 << 24) - 1;
	localparam int CS_UNSEEN  = 0;
	localparam int CS_OPEN    = 1;
	localparam int CS_CLOSED  = 2;

	typedef struct packed {
		logic [2:0] px;
		logic [2:0] py;
		logic       fnd;
		logic       lst;
	} path_word_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [9:0]  cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	grid_astar_path_search_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// search model state
	logic [8:0]      grid_cells [NCELLS];
	longint unsigned g_cost [NCELLS];
	longint unsigned f_cost [NCELLS];
	int              from_dir [NCELLS];
	int              cell_state [NCELLS];
	int              open_list [NCELLS];
	int              open_len;
	logic [3:0]      width_reg;
	logic [3:0]      height_reg;
	logic [9:0]      diag_reg;
	const int        step_dx [8] = '{0, 0, -1, 1, -1, 1, -1, 1};
	const int        step_dy [8] = '{1, -1, 0, 0, 1, 1, -1, -1};

	path_word_t path_q [$];
	int         fail_count;
	int         cycle_count;
	bit         idling;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int clamp_size(input logic [3:0] v);
		if (v == 4'd0) return 1;
		return (v > 4'd8) ? 8 : int'(v);
	endfunction

	function automatic longint unsigned sat_sum(input longint unsigned a, b);
		return (a + b > COST_SAT) ? COST_SAT : a + b;
	endfunction

	function automatic longint unsigned manhattan(input int x, y, gx, gy);
		int ax;
		int ay;
		ax = (x > gx) ? x - gx : gx - x;
		ay = (y > gy) ? y - gy : gy - y;
		return longint'(ax + ay) * 256;
	endfunction

	task automatic queue_word(input path_word_t pw);
		path_q.insert(path_q.size(), pw);
	endtask

	task automatic push_not_found();
		path_word_t pw;
		pw = '{px: 3'd0, py: 3'd0, fnd: 1'b0, lst: 1'b1};
		queue_word(pw);
	endtask

	task automatic predict_path(input int sx, sy, gx, gy);
		int w, h, s, i, d, best, cur, cx, cy, nx, ny, nb, len, at, px, py, n;
		longint unsigned step_len, stp, ng, nf;
		int trail [NCELLS];
		path_word_t pw;
		w = clamp_size(width_reg);
		h = clamp_size(height_reg);
		for (i = 0; i < NCELLS; i++) cell_state[i] = CS_UNSEEN;
		open_len = 0;
		if (sx >= w || sy >= h) begin
			push_not_found();
			return;
		end
		s = sy * 8 + sx;
		g_cost[s] = 0;
		f_cost[s] = manhattan(sx, sy, gx, gy);
		cell_state[s] = CS_OPEN;
		open_list[0] = s;
		open_len = 1;
		while (open_len > 0) begin
			best = 0;
			for (i = 1; i < open_len; i++)
				if (f_cost[open_list[i]] < f_cost[open_list[best]]) best = i;
			cur = open_list[best];
			for (i = best; i < open_len - 1; i++) open_list[i] = open_list[i + 1];
			open_len--;
			cx = cur % 8;
			cy = cur / 8;
			if (cx == gx && cy == gy) begin
				len = 0;
				at = cur;
				while (len < NCELLS) begin
					trail[len++] = at;
					if (at == s) break;
					px = at % 8 - step_dx[from_dir[at]];
					py = at / 8 - step_dy[from_dir[at]];
					if (px < 0 || py < 0 || px >= 8 || py >= 8) break;
					at = py * 8 + px;
				end
				n = 0;
				while (len > 0 && n < gaps_pkg::MAX_RESULTS) begin
					len--;
					pw.px = 3'(trail[len] % 8);
					pw.py = 3'(trail[len] / 8);
					pw.fnd = 1'b1;
					pw.lst = (len == 0 || n == gaps_pkg::MAX_RESULTS - 1);
					queue_word(pw);
					n++;
				end
				return;
			end
			cell_state[cur] = CS_CLOSED;
			for (d = 0; d < 8; d++) begin
				nx = cx + step_dx[d];
				ny = cy + step_dy[d];
				if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
				nb = ny * 8 + nx;
				if (grid_cells[nb][8]) continue;
				if (cell_state[nb] == CS_CLOSED) continue;
				step_len = (step_dx[d] != 0 && step_dy[d] != 0) ? longint'(diag_reg) : 256;
				stp = (step_len * (256 + 2 * longint'(grid_cells[nb][7:0]))) >> 8;
				ng = sat_sum(g_cost[cur], stp);
				nf = sat_sum(ng, manhattan(nx, ny, gx, gy));
				if (cell_state[nb] == CS_OPEN) begin
					if (ng < g_cost[nb]) begin
						g_cost[nb] = ng;
						f_cost[nb] = nf;
						from_dir[nb] = d;
					end
				end else if (open_len < NCELLS) begin
					g_cost[nb] = ng;
					f_cost[nb] = nf;
					from_dir[nb] = d;
					cell_state[nb] = CS_OPEN;
					open_list[open_len++] = nb;
				end
			end
		end
		push_not_found();
	endtask

	// send one word; model updated on acceptance
	task automatic send_word(input logic mode, input logic [26:0] fields);
		if (idling && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = mode;
		s_axis_tdata = {5'd0, fields};
		do @(posedge clk); while (!s_axis_tready);
		if (mode == gaps_pkg::MODE_LOAD)
			grid_cells[{fields[5:3], fields[2:0]}] = fields[14:6];
		else
			predict_path(fields[17:15], fields[20:18], fields[23:21], fields[26:24]);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic load_cell(input int x, y, cost, blk);
		send_word(gaps_pkg::MODE_LOAD, {12'd0, 1'(blk), 8'(cost), 3'(y), 3'(x)});
	endtask

	task automatic run_search(input int sx, sy, gx, gy);
		send_word(gaps_pkg::MODE_RUN, {3'(gy), 3'(gx), 3'(sy), 3'(sx), 15'd0});
	endtask

	task automatic wait_idle();
		while (path_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wr_data = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		if (idx == gaps_pkg::REG_GRID_WIDTH) width_reg = val[3:0];
		else if (idx == gaps_pkg::REG_GRID_HEIGHT) height_reg = val[3:0];
		else if (idx == gaps_pkg::REG_DIAG_COST) diag_reg = val;
	endtask

	task automatic set_grid(input int w, h, dg);
		wait_idle();
		write_reg(gaps_pkg::REG_GRID_WIDTH, 10'(w));
		write_reg(gaps_pkg::REG_GRID_HEIGHT, 10'(h));
		write_reg(gaps_pkg::REG_DIAG_COST, 10'(dg));
	endtask

	task automatic test_open_grid();
		int i;
		for (i = 0; i < NCELLS; i++) load_cell(i % 8, i / 8, 0, 0);
		run_search(0, 0, 7, 7);
		run_search(7, 7, 0, 0);
		run_search(3, 4, 3, 4);
	endtask

	task automatic test_obstacles();
		load_cell(4, 4, 255, 0);
		load_cell(3, 3, 255, 0);
		load_cell(2, 2, 0, 1);
		run_search(0, 0, 7, 7);
		run_search(2, 2, 5, 5);
		run_search(0, 0, 2, 2);
		run_search(2, 2, 2, 2);
		load_cell(6, 7, 0, 1);
		load_cell(6, 6, 0, 1);
		load_cell(7, 6, 0, 1);
		run_search(0, 0, 7, 7);
		load_cell(6, 6, 128, 0);
	endtask

	task automatic test_grid_size();
		set_grid(3, 2, 256);
		run_search(0, 0, 2, 1);
		run_search(5, 0, 1, 1);
		run_search(0, 0, 6, 6);
		set_grid(0, 0, 1023);
		run_search(0, 0, 0, 0);
		run_search(1, 0, 0, 0);
		set_grid(15, 15, 1023);
		run_search(0, 7, 7, 0);
		set_grid(8, 8, 362);
	endtask

	task automatic test_random(input int words);
		int k;
		for (k = 0; k < words; k++) begin
			if ($urandom_range(0, 2) == 0)
				run_search($urandom_range(0, 7), $urandom_range(0, 7),
					$urandom_range(0, 7), $urandom_range(0, 7));
			else
				load_cell($urandom_range(0, 7), $urandom_range(0, 7),
					$urandom_range(0, 255), $urandom_range(0, 4) == 0);
		end
	endtask

	always @(posedge clk) begin
		path_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (path_q.size() == 0) begin
				$display("%0t unexpected word: got x=%0d y=%0d found=%0b last=%0b", $time,
					m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tuser, m_axis_tlast);
				fail_count++;
			end else begin
				want = path_q.pop_front();
				if (m_axis_tdata[2:0] !== want.px || m_axis_tdata[5:3] !== want.py ||
						m_axis_tuser !== want.fnd || m_axis_tlast !== want.lst) begin
					$display({"%0t mismatch: exp x=%0d y=%0d found=%0b last=%0b, ",
						"got x=%0d y=%0d found=%0b last=%0b"},
						$time, want.px, want.py, want.fnd, want.lst, m_axis_tdata[2:0],
						m_axis_tdata[5:3], m_axis_tuser, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idling && $urandom_range(0, 7) == 0) begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			m_axis_tready = 1'b1;
		end
	end

	initial begin
		int p;
		fail_count = 0;
		cycle_count = 0;
		idling = 1'b1;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wr_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = gaps_pkg::MODE_LOAD;
		width_reg = gaps_pkg::GRID_SIZE_RST;
		height_reg = gaps_pkg::GRID_SIZE_RST;
		diag_reg = gaps_pkg::DIAG_COST_RST;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_open_grid();
		test_obstacles();
		test_grid_size();
		for (p = 0; p < 3; p++) begin
			test_random(50);
			set_grid($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(256, 1023));
		end
		set_grid(8, 8, 362);
		idling = 1'b0;
		test_random(60);
		while (path_q.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+design
design/gaps_pkg.sv
design/gaps_ram.sv
design/grid_astar_path_search_unit.sv
design/gaps_chk.sv
sim/tb_grid_astar_path_search_unit.sv
